[hdl/clns_pkg.sv]
// Shared types, command codes and constant tables of the character LCD nibble sequencer.
package clns_pkg;

    localparam int CMD_W          = 3;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSTR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NUMBER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GOTO   = 3'd4;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;

    localparam logic [2:0] INIT_LAST = 3'd5;
    localparam logic [2:0] POW_LAST  = 3'd4;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_BYTE,
        JOB_DEC
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        rs;
        logic [7:0]  byte_value;
        logic [15:0] number_value;
    } t_job;

    // Instruction bytes of the power-up sequence for 4-bit operation.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Decimal weights, most significant digit first.
    function automatic logic [13:0] dec_weight(input logic [2:0] idx);
        logic [13:0] w;
        case (idx)
            3'd0:    w = 14'd10000;
            3'd1:    w = 14'd1000;
            3'd2:    w = 14'd100;
            3'd3:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

[hdl/clns_front.sv]
// Front end: accepts requests and classifies them into jobs for the queue.
module clns_front (
    input  logic                      i_start,
    input  logic                      i_full,
    input  logic [clns_pkg::CMD_W-1:0] i_command,
    input  logic [7:0]                i_byte_value,
    input  logic [15:0]               i_number_value,
    input  logic                      i_row,
    input  logic [5:0]                i_column,
    output logic                      o_push,
    output clns_pkg::t_job            o_job
);

    logic w_known;

    always_comb begin
        w_known            = 1'b1;
        o_job.kind         = clns_pkg::JOB_BYTE;
        o_job.rs           = 1'b0;
        o_job.byte_value   = i_byte_value;
        o_job.number_value = i_number_value;
        unique case (i_command)
            clns_pkg::CMD_INIT: begin
                o_job.kind = clns_pkg::JOB_INIT;
            end
            clns_pkg::CMD_INSTR: begin
                o_job.kind = clns_pkg::JOB_BYTE;
            end
            clns_pkg::CMD_CHAR: begin
                o_job.rs = 1'b1;
            end
            clns_pkg::CMD_NUMBER: begin
                o_job.kind = clns_pkg::JOB_DEC;
                o_job.rs   = 1'b1;
            end
            clns_pkg::CMD_GOTO: begin
                o_job.byte_value = (i_row ? clns_pkg::ROW1_BASE : clns_pkg::ROW0_BASE)
                                   + {2'b00, i_column};
            end
            default: begin
                // Unused codes produce no writes and are dropped here.
                w_known = 1'b0;
            end
        endcase
    end

    assign o_push = i_start && !i_full && w_known;

endmodule

[hdl/clns_fifo.sv]
// Short job queue between the front end and the nibble back end.
module clns_fifo #(
    parameter int DEPTH = clns_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clns_pkg::t_job i_job,
    input  logic           i_pop,
    output clns_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clns_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/clns_back.sv]
// Back end: carries out one job at a time and emits registered nibble writes.
module clns_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clns_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_strobe,
    output logic           o_reg_select,
    output logic [3:0]     o_nibble,
    output logic           o_byte_done,
    output logic           o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_SEND
    } t_state;

    t_state              r_state;
    clns_pkg::t_job_kind r_kind;
    logic                r_rs;
    logic [7:0]          r_byte;
    logic                r_last_byte;
    logic                r_phase;
    logic [2:0]          r_idx;
    logic [15:0]         r_rem;
    logic [3:0]          r_digit;
    logic                r_started;
    logic                r_strobe;
    logic                r_reg_select;
    logic [3:0]          r_nibble;
    logic                r_byte_done;
    logic                r_last;
    logic [15:0]         w_weight;

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign w_weight = {2'b00, clns_pkg::dec_weight(r_idx)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_kind    <= i_job.kind;
                        r_rs      <= i_job.rs;
                        r_byte    <= i_job.byte_value;
                        r_rem     <= i_job.number_value;
                        r_idx     <= 3'd0;
                        r_digit   <= 4'd0;
                        r_started <= 1'b0;
                        r_phase   <= 1'b0;
                        r_last_byte <= 1'b1;
                        unique case (i_job.kind)
                            clns_pkg::JOB_INIT: r_state <= ST_INIT;
                            clns_pkg::JOB_DEC:  r_state <= ST_DIV;
                            default:            r_state <= ST_SEND;
                        endcase
                    end
                end
                ST_INIT: begin
                    r_byte      <= clns_pkg::init_byte(r_idx);
                    r_last_byte <= (r_idx == clns_pkg::INIT_LAST);
                    r_idx       <= r_idx + 1'b1;
                    r_state     <= ST_SEND;
                end
                ST_DIV: begin
                    // One subtraction of the current weight per cycle.
                    if (r_rem >= w_weight) begin
                        r_rem   <= r_rem - w_weight;
                        r_digit <= r_digit + 1'b1;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_digit <= 4'd0;
                        if (r_digit != 4'd0 || r_started || r_idx == clns_pkg::POW_LAST) begin
                            r_byte      <= clns_pkg::ASCII_ZERO + {4'b0000, r_digit};
                            r_started   <= 1'b1;
                            r_last_byte <= (r_idx == clns_pkg::POW_LAST);
                            r_state     <= ST_SEND;
                        end
                    end
                end
                ST_SEND: begin
                    r_strobe     <= 1'b1;
                    r_reg_select <= r_rs;
                    if (!r_phase) begin
                        r_nibble    <= r_byte[7:4];
                        r_byte_done <= 1'b0;
                        r_last      <= 1'b0;
                        r_phase     <= 1'b1;
                    end else begin
                        r_nibble    <= r_byte[3:0];
                        r_byte_done <= 1'b1;
                        r_last      <= r_last_byte;
                        r_phase     <= 1'b0;
                        if (r_last_byte) begin
                            r_state <= ST_IDLE;
                        end else if (r_kind == clns_pkg::JOB_INIT) begin
                            r_state <= ST_INIT;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe     = r_strobe;
    assign o_reg_select = r_reg_select;
    assign o_nibble     = r_nibble;
    assign o_byte_done  = r_byte_done;
    assign o_last       = r_last;

endmodule

[hdl/char_lcd_nibble_sequencer_top.sv]
// Top level of the character LCD nibble sequencer for 4-bit LCD mode.
//
// A request is taken at a rising edge where start is high and busy is low.
// The command selects the init sequence, an instruction byte, a data
// character, a decimal number or a cursor move. Unused command codes are
// dropped and cause no writes.
// Every byte leaves as two nibble writes, high nibble first, each shown for
// exactly one cycle with o_strobe high; o_byte_done marks the low nibble and
// o_last the final write of the request. The receiver cannot stall.
// Requests enter a short queue, so busy rises only while that queue is full.
// The back end handles one request at a time. A byte request passes from the
// queue into the back end registers and then to the output registers, which
// show its high nibble; the init sequence fetches each byte from its table and
// then sends it. A decimal number runs a serial subtract loop, one subtraction
// of 10000, 1000, 100, 10 or 1 per cycle; its run time is set by the digit
// values, with up to nine subtractions and one decision step per place and two
// nibble writes per printed digit.
// Synchronous reset empties the queue and returns the back end to idle; no
// write is in flight afterwards.
module char_lcd_nibble_sequencer_top #(
    parameter int FIFO_DEPTH = clns_pkg::FIFO_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [clns_pkg::CMD_W-1:0] i_command,
    input  logic [7:0]                 i_byte_value,
    input  logic [15:0]                i_number_value,
    input  logic                       i_row,
    input  logic [5:0]                 i_column,
    output logic                       o_strobe,
    output logic                       o_reg_select,
    output logic [3:0]                 o_nibble,
    output logic                       o_byte_done,
    output logic                       o_last
);

    clns_pkg::t_job w_push_job;
    clns_pkg::t_job w_head_job;
    logic           w_push;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;

    // Classification of the incoming request, including the cursor address.
    clns_front u_front (
        .i_start        (start),
        .i_full         (w_full),
        .i_command      (i_command),
        .i_byte_value   (i_byte_value),
        .i_number_value (i_number_value),
        .i_row          (i_row),
        .i_column       (i_column),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // The queue decouples request intake from the slow nibble output.
    clns_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // The back end walks the init table, the digit loop or a single byte.
    clns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_head_job),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_byte_done  (o_byte_done),
        .o_last       (o_last)
    );

    assign busy = w_full;

endmodule

[hdl/clns_checker.sv]
// Port-level checker of the nibble sequencer and its bind to the top level.
module clns_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_strobe,
    input logic o_reg_select,
    input logic o_byte_done,
    input logic o_last
);

    // Reset leaves no write in flight and the queue empty.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("write or busy seen right after reset");

    // A high nibble is always followed at once by its low nibble.
    a_nibble_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_byte_done |=> o_strobe && o_byte_done)
        else $error("high nibble not followed by low nibble");

    // Both nibbles of a byte carry the same register select.
    a_rs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_byte_done |=> o_reg_select == $past(o_reg_select))
        else $error("register select changed within a byte");

    // The final write of a request completes a byte.
    a_last_on_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> o_byte_done)
        else $error("last flag on a high nibble");

endmodule

bind char_lcd_nibble_sequencer_top clns_checker u_clns_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_reg_select (o_reg_select),
    .o_byte_done  (o_byte_done),
    .o_last       (o_last)
);
